@@ rtl/complex_arithmetic_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit - assertion macros
// Shared property wrappers for the unit's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Types, widths, codes and the saturating output helper of the complex unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int W  = 32;         // data width, Q16.16
    localparam int F  = 16;         // fractional bits
    localparam int PW = 2 * W;      // product width
    localparam int SW = 2 * W + 1;  // sum of two products

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [SW-1:0] LIM_POS = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [SW-1:0] LIM_NEG = LIM_POS + SW'(1);

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [W-1:0] a_re;
        logic signed [W-1:0] a_im;
        logic signed [W-1:0] b_re;
        logic signed [W-1:0] b_im;
    } t_cmd_item;

    typedef struct packed {
        logic signed [W-1:0] res_re;
        logic signed [W-1:0] res_im;
        logic [1:0]          status;
    } t_res_item;

    typedef struct packed {
        logic         sat;
        logic [W-1:0] val;
    } t_fin;

    // sign-magnitude to saturated two's complement
    function automatic t_fin fin_part(input logic neg, input logic [SW-1:0] mag,
                                      input logic ovf);
        t_fin          r;
        logic [SW-1:0] lim;
        logic [SW-1:0] m;
        logic [SW-1:0] v;
        lim   = neg ? LIM_NEG : LIM_POS;
        r.sat = ovf || (mag > lim);
        m     = r.sat ? lim : mag;
        v     = neg ? (~m + SW'(1)) : m;
        r.val = v[W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cau_div.sv @@
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider: floor((mag << F) / den), one quotient bit per
// stage, with an overflow flag when the quotient does not fit W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div
    import cau_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [SW-1:0] i_mag,
    input  wire logic [PW-1:0] i_den,
    output logic               o_vld,
    output logic [W-1:0]       o_q,
    output logic               o_ovf
);

    localparam int NW = SW + F;
    localparam int HW = NW - W;

    logic [NW-1:0] num;
    logic [HW-1:0] num_hi;
    logic [PW-1:0] hi_ext;
    logic          ovf0;

    logic          r_vld [0:W];
    logic [PW-1:0] r_rem [0:W];
    logic [W-1:0]  r_lo  [0:W];
    logic [PW-1:0] r_den [0:W];
    logic [W-1:0]  r_q   [0:W];
    logic          r_ovf [0:W];

    assign num    = NW'(i_mag) << F;
    assign num_hi = num[NW-1:W];
    assign hi_ext = PW'(num_hi);
    // quotient fits W bits only when the top part is below the divisor
    assign ovf0   = hi_ext >= i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0] <= ovf0 ? '0 : hi_ext;
        r_lo[0]  <= num[W-1:0];
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= ovf0;
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [PW:0] t;
        logic        ge;
        logic [PW:0] d;

        assign t  = {r_rem[k-1], r_lo[k-1][W-k]};
        assign ge = t >= {1'b0, r_den[k-1]};
        assign d  = t - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_rem[k] <= ge ? d[PW-1:0] : t[PW-1:0];
            r_lo[k]  <= r_lo[k-1];
            r_den[k] <= r_den[k-1];
            r_q[k]   <= {r_q[k-1][W-2:0], ge};
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    assign o_vld = r_vld[W];
    assign o_q   = r_q[W];
    assign o_ovf = r_ovf[W];

endmodule

`default_nettype wire

@@ rtl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Add, subtract, multiply and divide of Q16.16 complex operands, saturating.
//
//  channel   | ports                     | transfer
//  ----------+---------------------------+-------------------------------
//  command   | i_start, o_busy, i_item   | i_start high while o_busy low
//  result    | o_valid, o_result         | o_valid high, one cycle
//
// One command per cycle and one result per command, delayed alike for every
// code; the length is set by the divider, one quotient bit per stage, and the
// other codes run in a matching delay line so results leave in order.
// o_busy stays low: nothing in the pipeline ever holds.
// Synchronous active-low reset clears the valid bits and the side-data delay line.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    output logic           o_busy,
    input  wire t_cmd_item i_item,
    output logic           o_valid,
    output t_res_item      o_result
);

    localparam int LAT = W + 4;

    typedef struct packed {
        logic         vld;
        logic         is_div;
        logic         div0;
        logic         neg_re;
        logic         neg_im;
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic         sat;
    } t_side;

    logic accept;
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // stage 1: products and add/sub sums
    logic                 r1_vld;
    logic [1:0]           r1_cmd;
    logic signed [PW-1:0] r1_rr, r1_ii, r1_ri, r1_ir, r1_bbr, r1_bbi;
    logic signed [W:0]    r1_as_re, r1_as_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
        r1_cmd <= i_item.cmd;
        r1_rr  <= i_item.a_re * i_item.b_re;
        r1_ii  <= i_item.a_im * i_item.b_im;
        r1_ri  <= i_item.a_re * i_item.b_im;
        r1_ir  <= i_item.a_im * i_item.b_re;
        r1_bbr <= i_item.b_re * i_item.b_re;
        r1_bbi <= i_item.b_im * i_item.b_im;
        if (i_item.cmd == OP_SUB) begin
            r1_as_re <= (W+1)'(i_item.a_re) - (W+1)'(i_item.b_re);
            r1_as_im <= (W+1)'(i_item.a_im) - (W+1)'(i_item.b_im);
        end else begin
            r1_as_re <= (W+1)'(i_item.a_re) + (W+1)'(i_item.b_re);
            r1_as_im <= (W+1)'(i_item.a_im) + (W+1)'(i_item.b_im);
        end
    end

    // stage 2: cross sums to sign-magnitude, divisor, add/sub saturation
    logic                 div1;
    logic signed [SW-1:0] s_re, s_im;
    logic                 as_sat_re, as_sat_im;
    logic [W-1:0]         as_re, as_im;

    assign div1 = r1_cmd == OP_DIV;
    assign s_re = div1 ? SW'(r1_rr) + SW'(r1_ii) : SW'(r1_rr) - SW'(r1_ii);
    assign s_im = div1 ? SW'(r1_ir) - SW'(r1_ri) : SW'(r1_ri) + SW'(r1_ir);

    assign as_sat_re = r1_as_re[W] != r1_as_re[W-1];
    assign as_sat_im = r1_as_im[W] != r1_as_im[W-1];
    assign as_re = as_sat_re ? {r1_as_re[W], {(W-1){~r1_as_re[W]}}} : r1_as_re[W-1:0];
    assign as_im = as_sat_im ? {r1_as_im[W], {(W-1){~r1_as_im[W]}}} : r1_as_im[W-1:0];

    logic          r2_vld;
    logic [1:0]    r2_cmd;
    logic          r2_neg_re, r2_neg_im;
    logic [SW-1:0] r2_mag_re, r2_mag_im;
    logic [PW-1:0] r2_den;
    logic [W-1:0]  r2_as_re, r2_as_im;
    logic          r2_as_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_cmd    <= r1_cmd;
        r2_neg_re <= s_re[SW-1];
        r2_neg_im <= s_im[SW-1];
        r2_mag_re <= s_re[SW-1] ? SW'(-s_re) : SW'(s_re);
        r2_mag_im <= s_im[SW-1] ? SW'(-s_im) : SW'(s_im);
        r2_den    <= PW'(r1_bbr) + PW'(r1_bbi);
        r2_as_re  <= as_re;
        r2_as_im  <= as_im;
        r2_as_sat <= as_sat_re || as_sat_im;
    end

    // stage 3: product scaling; divider takes the same registers
    t_fin  mf_re, mf_im;
    t_side n_s3;

    assign mf_re = fin_part(r2_neg_re, r2_mag_re >> F, 1'b0);
    assign mf_im = fin_part(r2_neg_im, r2_mag_im >> F, 1'b0);

    always_comb begin
        n_s3        = '0;
        n_s3.vld    = r2_vld;
        n_s3.is_div = r2_cmd == OP_DIV;
        n_s3.div0   = r2_den == '0;
        n_s3.neg_re = r2_neg_re;
        n_s3.neg_im = r2_neg_im;
        if (r2_cmd == OP_MUL) begin
            n_s3.re  = mf_re.val;
            n_s3.im  = mf_im.val;
            n_s3.sat = mf_re.sat || mf_im.sat;
        end else begin
            n_s3.re  = r2_as_re;
            n_s3.im  = r2_as_im;
            n_s3.sat = r2_as_sat;
        end
    end

    logic         dv_vld_re, dv_vld_im;
    logic [W-1:0] dv_q_re, dv_q_im;
    logic         dv_ovf_re, dv_ovf_im;

    cau_div u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_mag   (r2_mag_re),
        .i_den   (r2_den),
        .o_vld   (dv_vld_re),
        .o_q     (dv_q_re),
        .o_ovf   (dv_ovf_re)
    );

    cau_div u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_mag   (r2_mag_im),
        .i_den   (r2_den),
        .o_vld   (dv_vld_im),
        .o_q     (dv_q_im),
        .o_ovf   (dv_ovf_im)
    );

    // side data waits alongside the divider stages
    t_side r_dl [0:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl[0] <= '0;
        end else begin
            r_dl[0] <= n_s3;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl[k] <= '0;
            end else begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // output stage
    t_fin      df_re, df_im;
    t_side     sd;
    t_res_item n_result;

    assign sd    = r_dl[W];
    assign df_re = fin_part(sd.neg_re, SW'(dv_q_re), dv_ovf_re);
    assign df_im = fin_part(sd.neg_im, SW'(dv_q_im), dv_ovf_im);

    always_comb begin
        n_result = '0;
        if (sd.is_div && sd.div0) begin
            n_result.status = ST_DIV0;
        end else if (sd.is_div) begin
            n_result.res_re = df_re.val;
            n_result.res_im = df_im.val;
            n_result.status = (df_re.sat || df_im.sat) ? ST_SAT : ST_OK;
        end else begin
            n_result.res_re = sd.re;
            n_result.res_im = sd.im;
            n_result.status = sd.sat ? ST_SAT : ST_OK;
        end
    end

    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= sd.vld;
        end
        o_result <= n_result;
    end

    assign o_valid = r_valid;

    `CAU_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(accept, LAT),
                    "result without command")
    `CAU_ASSERT_IMP(a_div0_zero, i_clk, i_rst_n, o_valid && o_result.status == ST_DIV0,
                    o_result.res_re == '0 && o_result.res_im == '0,
                    "nonzero divide-by-zero result")
    `CAU_ASSERT_IMP(a_div_align, i_clk, i_rst_n, sd.vld && sd.is_div,
                    dv_vld_re && dv_vld_im, "divider out of step")

endmodule

`default_nettype wire

@@ bench/cau_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cau_result_checker
// Watches the command and result channels of the complex arithmetic unit.
// Works out each result from the accepted command and compares it, field by
// field, with what the unit gives, in order.
// ----------------------------------------------------------------------------
module cau_result_checker
    import cau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_cmd_item i_item,
    input  logic      i_valid,
    input  t_res_item i_result,
    output int        o_errors,
    output int        o_pending
);

    t_res_item due_q[$];
    int        errors = 0;
    int        pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;

    // sign and magnitude to saturated Q16.16, top bit flags saturation
    function automatic logic [32:0] clamp_part(input logic neg, input logic [127:0] mag);
        logic [127:0] lim;
        logic [127:0] m;
        logic         sat;
        logic [31:0]  v;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        sat = mag > lim;
        m   = sat ? lim : mag;
        v   = neg ? (32'd0 - m[31:0]) : m[31:0];
        return {sat, v};
    endfunction

    function automatic logic [127:0] mag_of(input logic signed [67:0] s);
        logic signed [67:0] a;
        a = (s < 0) ? -s : s;
        return {60'd0, a};
    endfunction

    function automatic t_res_item complex_result(input t_cmd_item c);
        t_res_item          r;
        logic signed [67:0] ar, ai, br, bi;
        logic signed [67:0] s_re, s_im, den;
        logic [32:0]        p_re, p_im;
        logic [127:0]       d;
        ar = c.a_re; ai = c.a_im; br = c.b_re; bi = c.b_im;
        r = '0;
        p_re = '0;
        p_im = '0;
        case (c.cmd)
            OP_ADD: begin
                s_re = ar + br;
                s_im = ai + bi;
                p_re = clamp_part(s_re < 0, mag_of(s_re));
                p_im = clamp_part(s_im < 0, mag_of(s_im));
            end
            OP_SUB: begin
                s_re = ar - br;
                s_im = ai - bi;
                p_re = clamp_part(s_re < 0, mag_of(s_re));
                p_im = clamp_part(s_im < 0, mag_of(s_im));
            end
            OP_MUL: begin
                s_re = ar * br - ai * bi;
                s_im = ar * bi + ai * br;
                // truncation toward zero: shift the magnitude
                p_re = clamp_part(s_re < 0, mag_of(s_re) >> F);
                p_im = clamp_part(s_im < 0, mag_of(s_im) >> F);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DIV0;
                end else begin
                    d    = mag_of(den);
                    s_re = ar * br + ai * bi;
                    s_im = ai * br - ar * bi;
                    p_re = clamp_part(s_re < 0, (mag_of(s_re) << F) / d);
                    p_im = clamp_part(s_im < 0, (mag_of(s_im) << F) / d);
                end
            end
        endcase
        r.res_re = p_re[31:0];
        r.res_im = p_im[31:0];
        if (p_re[32] || p_im[32])
            r.status = ST_SAT;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res_item due;
        if (i_rst_n) begin
            if (i_valid) begin
                if (due_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected result, expected none, actual %h", $realtime,
                             i_result);
                end else begin
                    due = due_q.pop_front();
                    if (due.res_re !== i_result.res_re) begin
                        errors = errors + 1;
                        $display("%0t: res_re expected %h actual %h", $realtime,
                                 due.res_re, i_result.res_re);
                    end
                    if (due.res_im !== i_result.res_im) begin
                        errors = errors + 1;
                        $display("%0t: res_im expected %h actual %h", $realtime,
                                 due.res_im, i_result.res_im);
                    end
                    if (due.status !== i_result.status) begin
                        errors = errors + 1;
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 due.status, i_result.status);
                    end
                end
            end
            if (i_start && !i_busy)
                due_q.push_back(complex_result(i_item));
            pending = due_q.size();
        end
    end

endmodule

@@ bench/tb_complex_arithmetic_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives directed and random complex commands into the unit in phases of
// differing sender idling; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit
    import cau_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 80;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_cmd_item i_item = '0;
    logic      o_busy;
    logic      o_valid;
    t_res_item o_result;
    int        errors;
    int        pending;
    int        cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    complex_arithmetic_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    cau_result_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_busy    (o_busy),
        .i_item    (i_item),
        .i_valid   (o_valid),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] ar, input logic [31:0] ai,
                            input logic [31:0] br, input logic [31:0] bi);
        logic busy_now;
        i_start <= 1'b1;
        i_item  <= '{cmd: cmd, a_re: ar, a_im: ai, b_re: br, b_im: bi};
        do begin
            busy_now = o_busy;
            @(negedge i_clk);
        end while (busy_now);
    endtask

    task automatic idle_cycle();
        i_start <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:       return 32'($signed($urandom_range(0, 255)) - 32'sd128) << 12;
            4:       return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic random_phase(input int count, input int idle_pct);
        logic [31:0] br, bi;
        for (int n = 0; n < count; n++) begin
            while ($urandom_range(1, 100) <= idle_pct)
                idle_cycle();
            br = rand_part();
            bi = rand_part();
            if ($urandom_range(0, 19) == 0) begin
                br = '0;
                bi = '0;
            end else if ($urandom_range(0, 9) == 0) begin
                bi = '0;
            end
            send_cmd(2'($urandom_range(0, 3)), rand_part(), rand_part(), br, bi);
        end
        // hold off until every outstanding result has come back
        i_start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_cmd(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        send_cmd(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_cmd(OP_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(OP_SUB, 32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
        send_cmd(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
        send_cmd(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cmd(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_cmd(OP_MUL, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_cmd(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000);
        send_cmd(OP_DIV, 32'hFFFF_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
        send_cmd(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        send_cmd(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cmd(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cmd(OP_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000);
        send_cmd(OP_DIV, 32'h0005_0000, 32'hFFFD_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        idle_cycle();

        random_phase(400, 0);
        random_phase(400, 69);
        random_phase(350, 0);
        random_phase(400, 23);

        i_start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
